@@ rtl/ffl_pkg.sv @@
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared types and constants for the free-list ID allocator.
// ----------------------------------------------------------------------------
package ffl_pkg;

  localparam int DEPTH       = 64;
  localparam int ID_W        = 6;
  localparam int CNT_W       = 7;
  localparam int HANDLE_W    = 32;
  localparam int RATIO_W     = 4;
  localparam int PROD_W      = CNT_W + RATIO_W;
  localparam int STEP_W      = $clog2(RATIO_W + 1);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_ERASE   = 2'd1,
    CMD_FIND    = 2'd2,
    CMD_CLEANUP = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_NOTLIVE = 2'd2,
    STS_SKIPPED = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_THR,
    ST_SCAN,
    ST_EMIT
  } state_e_t;

  typedef struct packed {
    cmd_e_t               cmd;
    logic [HANDLE_W-1:0]  handle;
    logic [ID_W-1:0]      id;
  } in_t;

  typedef struct packed {
    status_e_t            status;
    logic [ID_W-1:0]      id_res;
    logic [ID_W-1:0]      old_id;
    logic [HANDLE_W-1:0]  handle_res;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [CNT_W-1:0]   live;
    logic [RATIO_W-1:0] ratio;
    logic [CNT_W-1:0]   lim;
  } thr_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic exceed;
  } thr_sts_t;

endpackage

@@ rtl/fifo_free_list_id_allocator.sv @@
// ----------------------------------------------------------------------------
// fifo_free_list_id_allocator
// Handle table with a FIFO free list of IDs, lookup, and in-order compaction
// driven by a small sequencer and a shift-add threshold unit.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  cmd, handle, id
//   out_     output     out_valid/out_stall status, id_res, old_id, handle_res, last
//   cfg_     input      cfg_we             cleanup_ratio
//
// Insert, erase and find: the memory read is registered on the accept edge,
//   then EXEC updates and loads the result register once it is free.
// Cleanup: the threshold multiply runs in THR after accept, then EXEC gives a
//   skipped result, or SCAN steps over each dead entry and sends each live
//   entry through EMIT up to the list size; a new word is taken only in IDLE.
// Reset is synchronous; live bits clear at once, the memories need no pass.
// A result waits in the output register under out_stall; the next word is
//   accepted meanwhile, and the sequencer holds if the register is still full.
// ----------------------------------------------------------------------------
module fifo_free_list_id_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ffl_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ffl_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ffl_pkg::RATIO_W-1:0]    cfg_wdata
);
  import ffl_pkg::*;

  logic [HANDLE_W-1:0] tbl_mem [DEPTH];
  logic [ID_W-1:0]     fifo_mem [DEPTH];

  state_e_t            state_r, state_nxt;
  logic [DEPTH-1:0]    live_r, live_nxt;
  logic [ID_W-1:0]     free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [CNT_W-1:0]    list_size_r, list_size_nxt;
  logic [CNT_W-1:0]    live_count_r, live_count_nxt;
  logic [RATIO_W-1:0]  ratio_r;
  logic [CNT_W-1:0]    scan_i_r, scan_i_nxt;
  logic [CNT_W-1:0]    wr_n_r, wr_n_nxt;
  in_t                 word_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  logic [HANDLE_W-1:0] tbl_rdata_r;
  logic [ID_W-1:0]     fifo_rdata_r;
  logic                tbl_we, tbl_re, fifo_we, fifo_re;
  logic [ID_W-1:0]     tbl_waddr, tbl_raddr, fifo_waddr;
  logic [HANDLE_W-1:0] tbl_wdata;

  logic                accept, out_free, last_live;
  logic [DEPTH-1:0]    rem_mask;
  thr_req_t            thr_req;
  thr_sts_t            thr_sts;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      rem_mask[j] = (CNT_W'(j) > scan_i_r) && (CNT_W'(j) < list_size_r);
    end
  end
  assign last_live = ~|(live_r & rem_mask);

  assign thr_req.start = accept && (in_data.cmd == CMD_CLEANUP);
  assign thr_req.live  = live_count_r;
  assign thr_req.ratio = ratio_r;
  assign thr_req.lim   = list_size_r;

  ffl_thr u_thr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (thr_req),
    .sts   (thr_sts)
  );

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    list_size_nxt  = list_size_r;
    live_count_nxt = live_count_r;
    scan_i_nxt     = scan_i_r;
    wr_n_nxt       = wr_n_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    fifo_we        = 1'b0;
    fifo_re        = 1'b0;
    tbl_waddr      = '0;
    tbl_raddr      = in_data.id;
    tbl_wdata      = word_r.handle;
    fifo_waddr     = free_head_r + free_count_r[ID_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tbl_re  = 1'b1;
          fifo_re = 1'b1;
          state_nxt = (in_data.cmd == CMD_CLEANUP) ? ST_THR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = STS_OK;
          out_nxt.id_res     = word_r.id;
          out_nxt.old_id     = '0;
          out_nxt.handle_res = '0;
          out_nxt.last       = 1'b1;
          state_nxt          = ST_IDLE;
          case (word_r.cmd)
            CMD_INSERT: begin
              if (free_count_r != '0) begin
                tbl_waddr      = fifo_rdata_r;
                free_head_nxt  = free_head_r + ID_W'(1);
                free_count_nxt = free_count_r - CNT_W'(1);
              end else if (list_size_r != CNT_W'(DEPTH)) begin
                tbl_waddr     = list_size_r[ID_W-1:0];
                list_size_nxt = list_size_r + CNT_W'(1);
              end
              if (free_count_r == '0 && list_size_r == CNT_W'(DEPTH)) begin
                out_nxt.status = STS_FULL;
                out_nxt.id_res = '0;
              end else begin
                tbl_we              = 1'b1;
                live_nxt[tbl_waddr] = 1'b1;
                live_count_nxt      = live_count_r + CNT_W'(1);
                out_nxt.id_res      = tbl_waddr;
              end
            end
            CMD_ERASE: begin
              if (!live_r[word_r.id]) begin
                out_nxt.status = STS_NOTLIVE;
              end else begin
                live_nxt[word_r.id] = 1'b0;
                if (free_count_r < CNT_W'(DEPTH)) begin
                  fifo_we        = 1'b1;
                  free_count_nxt = free_count_r + CNT_W'(1);
                end
                if (live_count_r != '0) begin
                  live_count_nxt = live_count_r - CNT_W'(1);
                end
              end
            end
            CMD_FIND: begin
              if (!live_r[word_r.id]) begin
                out_nxt.status = STS_NOTLIVE;
              end else begin
                out_nxt.handle_res = tbl_rdata_r;
              end
            end
            default: begin
              out_nxt.status = STS_SKIPPED;
              out_nxt.id_res = '0;
            end
          endcase
        end
      end
      ST_THR: begin
        if (thr_sts.done) begin
          if (thr_sts.exceed) begin
            free_head_nxt  = '0;
            free_count_nxt = '0;
            scan_i_nxt     = '0;
            wr_n_nxt       = '0;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        tbl_raddr = scan_i_r[ID_W-1:0];
        if (scan_i_r == list_size_r) begin
          list_size_nxt  = wr_n_r;
          live_count_nxt = wr_n_r;
          state_nxt      = ST_IDLE;
        end else if (live_r[scan_i_r[ID_W-1:0]]) begin
          tbl_re    = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = STS_OK;
          out_nxt.id_res     = wr_n_r[ID_W-1:0];
          out_nxt.old_id     = scan_i_r[ID_W-1:0];
          out_nxt.handle_res = tbl_rdata_r;
          out_nxt.last       = last_live;
          tbl_we             = 1'b1;
          tbl_waddr          = wr_n_r[ID_W-1:0];
          tbl_wdata          = tbl_rdata_r;
          live_nxt[scan_i_r[ID_W-1:0]] = 1'b0;
          live_nxt[wr_n_r[ID_W-1:0]]   = 1'b1;
          wr_n_nxt   = wr_n_r + CNT_W'(1);
          scan_i_nxt = scan_i_r + CNT_W'(1);
          state_nxt  = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_r       <= '0;
      free_head_r  <= '0;
      free_count_r <= '0;
      list_size_r  <= '0;
      live_count_r <= '0;
      ratio_r      <= RATIO_RESET;
      out_valid_r  <= 1'b0;
      scan_i_r     <= '0;
      wr_n_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      list_size_r  <= list_size_nxt;
      live_count_r <= live_count_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_i_r     <= scan_i_nxt;
      wr_n_r       <= wr_n_nxt;
      if (cfg_we) begin
        ratio_r <= cfg_wdata;
      end
    end
    out_r <= out_nxt;
    if (accept) begin
      word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_r <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= word_r.id;
    end
    if (fifo_re) begin
      fifo_rdata_r <= fifo_mem[free_head_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (free_count_r + live_count_r) == list_size_r)
    else $error("free and live counts do not add up to list size");

  a_pack_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_EMIT) |-> wr_n_r <= scan_i_r)
    else $error("compaction write index ahead of scan index");

  a_thr_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (thr_sts.busy || thr_sts.done) |-> state_r == ST_THR)
    else $error("threshold unit active outside the wait state");

  a_live_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= list_size_r && list_size_r <= CNT_W'(DEPTH))
    else $error("live count or list size out of range");

endmodule

@@ rtl/ffl_thr.sv @@
// ----------------------------------------------------------------------------
// ffl_thr
// Shift-add multiplier and compare for the compaction threshold: one adder
// used once per ratio bit, then list size is compared against the product.
// ----------------------------------------------------------------------------
module ffl_thr (
  input  logic            clk,
  input  logic            rst_n,
  input  ffl_pkg::thr_req_t req,
  output ffl_pkg::thr_sts_t sts
);
  import ffl_pkg::*;

  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0]  mcand_r, mcand_nxt;
  logic [RATIO_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    lim_nxt    = lim_r;
    step_nxt   = step_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(req.live);
      mplier_nxt = req.ratio;
      lim_nxt    = req.lim;
      step_nxt   = STEP_W'(RATIO_W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      step_nxt   = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    lim_r    <= lim_nxt;
  end

  assign sts.busy   = busy_r;
  assign sts.done   = done_r;
  assign sts.exceed = PROD_W'(lim_r) > acc_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("threshold done while still busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("threshold done without a run");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != '0)
    else $error("threshold busy with no step left");

endmodule
